@@ rtl/bafcw_pkg.sv @@
// ----------------------------------------------------------------------------
// BLE advertising frame coder package
// Shared types, constants and the byte-wide CRC-24, whitening and
// bit-reversal functions used by the frame coder.
// ----------------------------------------------------------------------------
package bafcw_pkg;

    // CRC-24 seed and reflected polynomial mask.
    localparam logic [23:0] CRC_SEED = 24'hAAAAAA;
    localparam logic [23:0] CRC_MASK = 24'hDA6000;

    // Whitening LFSR taps and the bit that is forced on in the seed.
    localparam logic [6:0] LFSR_TAPS = 7'h44;
    localparam logic [6:0] LFSR_TOP  = 7'h40;

    // Byte position counter saturates here.
    localparam logic [5:0] COUNT_MAX = 6'd63;

    // Accepted length range for a received frame.
    localparam logic [7:0] LEN_MIN           = 8'd6;
    localparam logic [7:0] MAX_PAYLOAD_BYTES = 8'd27;

    // Register reset values.
    localparam logic [5:0] CHANNEL_RESET = 6'd37;

    // Configuration register indexes.
    localparam logic CFG_IDX_CHANNEL   = 1'b0;
    localparam logic CFG_IDX_DIRECTION = 1'b1;

    // Direction codes.
    localparam logic DIR_TX = 1'b0;
    localparam logic DIR_RX = 1'b1;

    // Check status codes.
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_CRC = 2'd1;
    localparam logic [1:0] ST_LEN = 2'd2;

    // Configuration seen by the coder.
    typedef struct packed {
        logic [5:0] channel;
        logic       direction;
    } t_cfg;

    // One input word.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } t_in_word;

    // One result word.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       check_done;
        logic [1:0] check_status;
    } t_result;

    // Feed one byte into the LSB-first CRC-24.
    function automatic logic [23:0] crc24_byte(input logic [23:0] crc, input logic [7:0] b);
        logic [23:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = b[i] ^ c[0];
            c  = c >> 1;
            if (fb) begin
                c = c ^ CRC_MASK;
            end
        end
        return c;
    endfunction

    // Eight whitening bits produced from the LFSR, first bit in bit 0.
    function automatic logic [7:0] whiten_mask(input logic [6:0] lfsr);
        logic [6:0] l;
        logic [7:0] m;
        l = lfsr;
        m = 8'd0;
        for (int i = 0; i < 8; i++) begin
            m[i] = l[0];
            if (l[0]) begin
                l = (l >> 1) ^ LFSR_TAPS;
            end else begin
                l = l >> 1;
            end
        end
        return m;
    endfunction

    // LFSR state after eight steps.
    function automatic logic [6:0] whiten_next(input logic [6:0] lfsr);
        logic [6:0] l;
        l = lfsr;
        for (int i = 0; i < 8; i++) begin
            if (l[0]) begin
                l = (l >> 1) ^ LFSR_TAPS;
            end else begin
                l = l >> 1;
            end
        end
        return l;
    endfunction

    // Reverse the bit order of a byte.
    function automatic logic [7:0] rev8(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[7 - i] = b[i];
        end
        return r;
    endfunction

endpackage

@@ rtl/ble_adv_frame_crc_whiten.sv @@
// ----------------------------------------------------------------------------
// BLE advertising frame coder
// Transmit: CRC-24, whitening, bit reversal and CRC append.
// Receive: bit reversal, dewhitening, length check and CRC check.
// ----------------------------------------------------------------------------
// Path: an accepted byte passes the input register, then the result register.
// Throughput: one byte per cycle while the output is not stalled; a transmit byte
// marked last then emits three CRC bytes, one per cycle, holding the input off.
// The rate is set by the single result register shared by data and CRC bytes.
// Reset (synchronous, active low) clears the pipeline, restores channel 37 and
// transmit direction, and seeds the CRC and whitening state.
module ble_adv_frame_crc_whiten (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Configuration write channel.
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic [5:0] i_cfg_data,
    // Input stream.
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tuser,   // [0] first_byte
    input  logic       s_axis_tlast,   // last_byte
    // Output stream.
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [2:0] m_axis_tuser,   // [0] check_done, [2:1] check_status
    output logic       m_axis_tlast    // out_last
);
    import bafcw_pkg::*;

    t_cfg     r_cfg;
    t_in_word w_in_word;
    t_in_word w_stage_word;
    logic     w_stage_valid;
    logic     w_stage_ready;
    t_result  w_result;

    // Configuration registers; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channel   <= CHANNEL_RESET;
            r_cfg.direction <= DIR_TX;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IDX_CHANNEL:   r_cfg.channel   <= i_cfg_data;
                CFG_IDX_DIRECTION: r_cfg.direction <= i_cfg_data[0];
                default:           r_cfg           <= r_cfg;
            endcase
        end
    end

    // Input word assembly.
    assign w_in_word = '{data_byte: s_axis_tdata, first_byte: s_axis_tuser,
                         last_byte: s_axis_tlast};

    bafcw_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_word  (w_in_word),
        .o_valid (w_stage_valid),
        .i_ready (w_stage_ready),
        .o_word  (w_stage_word)
    );

    bafcw_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_word_valid   (w_stage_valid),
        .o_word_ready   (w_stage_ready),
        .i_word         (w_stage_word),
        .o_result_valid (m_axis_tvalid),
        .i_result_ready (m_axis_tready),
        .o_result       (w_result)
    );

    // Output word unpacking.
    assign m_axis_tdata = w_result.out_byte;
    assign m_axis_tuser = {w_result.check_status, w_result.check_done};
    assign m_axis_tlast = w_result.out_last;

endmodule

@@ rtl/bafcw_in_stage.sv @@
// ----------------------------------------------------------------------------
// Frame coder input register
// Captures one input word per cycle and holds it until the coder takes it.
// ----------------------------------------------------------------------------
module bafcw_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  bafcw_pkg::t_in_word i_word,
    output logic               o_valid,
    input  logic               i_ready,
    output bafcw_pkg::t_in_word o_word
);
    import bafcw_pkg::*;

    logic     r_valid;
    t_in_word r_word;

    // The register is free when empty or when its word leaves this cycle.
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= i_word;
        end
    end

endmodule

@@ rtl/bafcw_core.sv @@
// ----------------------------------------------------------------------------
// Frame coder core
// Holds the CRC, whitening and frame counters, codes one word per cycle
// when not stalled into the result register, then appends CRC after TX frames.
// ----------------------------------------------------------------------------
module bafcw_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bafcw_pkg::t_cfg     i_cfg,
    input  logic                i_word_valid,
    output logic                o_word_ready,
    input  bafcw_pkg::t_in_word i_word,
    output logic                o_result_valid,
    input  logic                i_result_ready,
    output bafcw_pkg::t_result  o_result
);
    import bafcw_pkg::*;

    // Frame state.
    logic [23:0] r_crc;
    logic [6:0]  r_lfsr;
    logic [5:0]  r_cnt;
    logic [7:0]  r_flen;
    logic        r_mism;

    // CRC append sequencer.
    logic        r_app_busy;
    logic [1:0]  r_app_idx;
    logic [1:0]  r_app_status;

    // Result register.
    logic        r_out_valid;
    t_result     r_out;

    // Next values.
    logic [23:0] n_crc;
    logic [6:0]  n_lfsr;
    logic [5:0]  n_cnt;
    logic [7:0]  n_flen;
    logic        n_mism;
    t_result     n_res;
    t_result     n_app_res;

    // State as seen by this word after a frame restart.
    logic [23:0] w_crc;
    logic [6:0]  w_lfsr;
    logic [5:0]  w_pos;
    logic [7:0]  w_flen;
    logic        w_mism;
    logic [7:0]  w_mask;
    logic [7:0]  w_dec;
    logic        w_ok_len;
    logic [8:0]  w_diff;
    logic [7:0]  w_exp;
    logic [7:0]  w_app_byte;

    logic        w_out_free;
    logic        w_take;
    logic        w_app_step;

    // Handshake.
    assign w_out_free     = !r_out_valid || i_result_ready;
    assign w_take         = i_word_valid && !r_app_busy && w_out_free;
    assign w_app_step     = r_app_busy && w_out_free;
    assign o_word_ready   = !r_app_busy && w_out_free;
    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

    // Per-word coding.
    always_comb begin
        if (i_word.first_byte) begin
            w_crc  = CRC_SEED;
            w_lfsr = {1'b0, i_cfg.channel} | LFSR_TOP;
            w_pos  = 6'd0;
            w_flen = 8'd0;
            w_mism = 1'b0;
        end else begin
            w_crc  = r_crc;
            w_lfsr = r_lfsr;
            w_pos  = r_cnt;
            w_flen = r_flen;
            w_mism = r_mism;
        end

        n_cnt  = (w_pos < COUNT_MAX) ? w_pos + 6'd1 : w_pos;
        w_mask = whiten_mask(w_lfsr);
        n_lfsr = whiten_next(w_lfsr);
        w_dec  = rev8(i_word.data_byte) ^ w_mask;

        n_crc  = w_crc;
        n_flen = w_flen;
        n_mism = w_mism;
        n_res  = '{out_byte: w_dec, out_last: 1'b0, check_done: 1'b0,
                   check_status: ST_OK};

        w_ok_len = 1'b0;
        w_diff   = 9'd0;
        w_exp    = 8'd0;

        if (i_cfg.direction == DIR_TX) begin
            // Transmit: CRC over the raw byte, whiten, then reverse.
            if (w_pos == 6'd1) begin
                n_flen = i_word.data_byte;
            end
            n_crc = crc24_byte(w_crc, i_word.data_byte);
            n_res.out_byte = rev8(i_word.data_byte ^ w_mask);
        end else begin
            // Receive: decode, track length, check the trailing CRC.
            if (w_pos == 6'd1) begin
                n_flen = w_dec;
            end
            w_ok_len = (n_flen >= LEN_MIN) && (n_flen <= MAX_PAYLOAD_BYTES);
            w_diff   = {3'b000, w_pos} - {1'b0, n_flen} - 9'd2;
            case (w_diff[1:0])
                2'd0:    w_exp = w_crc[7:0];
                2'd1:    w_exp = w_crc[15:8];
                2'd2:    w_exp = w_crc[23:16];
                default: w_exp = 8'd0;
            endcase
            if (w_pos < 6'd2) begin
                if (w_pos == 6'd1 && !w_ok_len) begin
                    n_res.out_last     = 1'b1;
                    n_res.check_done   = 1'b1;
                    n_res.check_status = ST_LEN;
                end else begin
                    n_crc = crc24_byte(w_crc, w_dec);
                end
            end else if (w_ok_len) begin
                if ({3'b000, w_pos} < {1'b0, n_flen} + 9'd2) begin
                    n_crc = crc24_byte(w_crc, w_dec);
                end else if ({3'b000, w_pos} <= {1'b0, n_flen} + 9'd4) begin
                    n_mism = w_mism | (w_exp != w_dec);
                    if (w_diff[1:0] == 2'd2) begin
                        n_res.out_last     = 1'b1;
                        n_res.check_done   = 1'b1;
                        n_res.check_status = n_mism ? ST_CRC : ST_OK;
                    end
                end
            end
        end
    end

    // Appended CRC byte, least significant first.
    always_comb begin
        case (r_app_idx)
            2'd0:    w_app_byte = r_crc[7:0];
            2'd1:    w_app_byte = r_crc[15:8];
            2'd2:    w_app_byte = r_crc[23:16];
            default: w_app_byte = 8'd0;
        endcase
        n_app_res = '{out_byte: rev8(w_app_byte ^ whiten_mask(r_lfsr)),
                      out_last: (r_app_idx == 2'd2),
                      check_done: (r_app_idx == 2'd2),
                      check_status: (r_app_idx == 2'd2) ? r_app_status : ST_OK};
    end

    // Frame state and append sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc        <= CRC_SEED;
            r_lfsr       <= {1'b0, CHANNEL_RESET} | LFSR_TOP;
            r_cnt        <= 6'd0;
            r_flen       <= 8'd0;
            r_mism       <= 1'b0;
            r_app_busy   <= 1'b0;
            r_app_idx    <= 2'd0;
            r_app_status <= ST_OK;
        end else if (w_take) begin
            r_crc  <= n_crc;
            r_lfsr <= n_lfsr;
            r_cnt  <= n_cnt;
            r_flen <= n_flen;
            r_mism <= n_mism;
            if (i_cfg.direction == DIR_TX && i_word.last_byte) begin
                r_app_busy   <= 1'b1;
                r_app_idx    <= 2'd0;
                r_app_status <= (n_flen > MAX_PAYLOAD_BYTES) ? ST_LEN : ST_OK;
            end
        end else if (w_app_step) begin
            r_lfsr    <= whiten_next(r_lfsr);
            r_app_idx <= r_app_idx + 2'd1;
            if (r_app_idx == 2'd2) begin
                r_app_busy <= 1'b0;
            end
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_take || w_app_step;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= n_res;
        end else if (w_app_step) begin
            r_out <= n_app_res;
        end
    end

endmodule

@@ test/ble_adv_frame_crc_whiten_tb.sv @@
// ----------------------------------------------------------------------------
// BLE advertising frame coder testbench
// Drives transmit and receive frames through the coder under several channel
// and direction settings, with random idle cycles on both streams. A local
// model of the CRC-24, the whitening register and the frame checks predicts
// every output word, and each word is compared field by field on arrival.
// ----------------------------------------------------------------------------
module ble_adv_frame_crc_whiten_tb;

    import bafcw_pkg::*;

    // Kinds of rows in the directed stimulus table.
    typedef enum {ROW_CHAN, ROW_DIR, ROW_BYTE, ROW_TX, ROW_RX} t_row_kind;

    // One directed row. For ROW_BYTE, fill is the data and val holds
    // {last_byte, first_byte}. For frames, fill seeds the byte pattern.
    typedef struct {
        t_row_kind  kind;
        logic [5:0] val;
        logic [7:0] len;
        int         body;
        logic [7:0] fill;
        bit         damage;
        bit         chk;
        logic [1:0] want;
    } t_plan_row;

    logic       i_clk;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_valid   = 1'b0;
    logic       i_cfg_index   = 1'b0;
    logic [5:0] i_cfg_data    = 6'd0;
    logic       s_axis_tvalid = 1'b0;
    logic [7:0] s_axis_tdata  = 8'd0;
    logic       s_axis_tuser  = 1'b0;
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tready = 1'b0;
    logic       o_cfg_ready;
    logic       s_axis_tready;
    logic       m_axis_tvalid;
    logic [7:0] m_axis_tdata;
    logic [2:0] m_axis_tuser;
    logic       m_axis_tlast;

    // Coder model state and its copy of the registers.
    logic [23:0] p_crc  = CRC_SEED;
    logic [6:0]  p_wh   = CHANNEL_RESET | LFSR_TOP;
    logic [5:0]  p_pos  = 6'd0;
    logic [7:0]  p_len  = 8'd0;
    logic        p_bad  = 1'b0;
    logic [5:0]  p_chan = CHANNEL_RESET;
    logic        p_dir  = DIR_TX;

    t_result     pending[$];
    t_plan_row   plan[$];
    logic [7:0]  frame_raw[$];
    logic [7:0]  frame_air[$];
    bit          typed_on   = 1'b0;
    logic [1:0]  typed_st   = ST_OK;
    bit          calm       = 1'b0;
    int          fed        = 0;
    int          mismatches = 0;

    ble_adv_frame_crc_whiten uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // LSB-first CRC-24 over one byte.
    function automatic logic [23:0] crc_after(input logic [23:0] c, input logic [7:0] b);
        logic [23:0] r;
        r = c;
        for (int i = 0; i < 8; i++) begin
            r = (r >> 1) ^ ((b[i] ^ r[0]) ? CRC_MASK : 24'h0);
        end
        return r;
    endfunction

    // Eight whitening bits from the LFSR; returns {next state, bits}.
    function automatic logic [14:0] wh_step(input logic [6:0] s);
        logic [6:0] l;
        logic [7:0] m;
        l = s;
        for (int i = 0; i < 8; i++) begin
            m[i] = l[0];
            l = (l >> 1) ^ (l[0] ? LFSR_TAPS : 7'h00);
        end
        return {l, m};
    endfunction

    function automatic logic [7:0] flip8(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = b[7 - i];
        end
        return r;
    endfunction

    // Queue one expected word; a typed status from the table replaces the
    // computed one on the check word of the frame.
    function automatic void note(input logic [7:0] b, input logic lst, input logic done,
                                 input logic [1:0] st);
        t_result r;
        r.out_byte     = b;
        r.out_last     = lst;
        r.check_done   = done;
        r.check_status = st;
        if (done && typed_on) begin
            r.check_status = typed_st;
            typed_on = 1'b0;
        end
        pending.push_back(r);
    endfunction

    // Work out the output words caused by one accepted input word.
    task automatic predict(input logic [7:0] d, input logic f, input logic l);
        int         at;
        int         lenv;
        int         k;
        logic [7:0] m;
        logic [7:0] v;
        logic [1:0] st;
        logic       len_ok;
        if (f) begin
            p_crc = CRC_SEED;
            p_wh  = p_chan | LFSR_TOP;
            p_pos = 6'd0;
            p_len = 8'd0;
            p_bad = 1'b0;
        end
        at = p_pos;
        if (p_pos != COUNT_MAX) begin
            p_pos = p_pos + 6'd1;
        end
        if (p_dir == DIR_TX) begin
            if (at == 1) begin
                p_len = d;
            end
            p_crc = crc_after(p_crc, d);
            {p_wh, m} = wh_step(p_wh);
            note(flip8(d ^ m), 1'b0, 1'b0, ST_OK);
            if (l) begin
                st = (p_len > MAX_PAYLOAD_BYTES) ? ST_LEN : ST_OK;
                for (k = 0; k < 3; k++) begin
                    {p_wh, m} = wh_step(p_wh);
                    note(flip8(p_crc[8 * k +: 8] ^ m), k == 2, k == 2, (k == 2) ? st : ST_OK);
                end
            end
        end else begin
            {p_wh, m} = wh_step(p_wh);
            v = flip8(d) ^ m;
            if (at == 1) begin
                p_len = v;
            end
            lenv   = p_len;
            len_ok = (p_len >= LEN_MIN) && (p_len <= MAX_PAYLOAD_BYTES);
            if (at == 1 && !len_ok) begin
                note(v, 1'b1, 1'b1, ST_LEN);
            end else if (at < 2) begin
                p_crc = crc_after(p_crc, v);
                note(v, 1'b0, 1'b0, ST_OK);
            end else if (!len_ok) begin
                note(v, 1'b0, 1'b0, ST_OK);
            end else if (at < lenv + 2) begin
                p_crc = crc_after(p_crc, v);
                note(v, 1'b0, 1'b0, ST_OK);
            end else if (at <= lenv + 4) begin
                // One of the three received CRC bytes.
                k = at - lenv - 2;
                if (p_crc[8 * k +: 8] != v) begin
                    p_bad = 1'b1;
                end
                if (k == 2) begin
                    note(v, 1'b1, 1'b1, p_bad ? ST_CRC : ST_OK);
                end else begin
                    note(v, 1'b0, 1'b0, ST_OK);
                end
            end else begin
                note(v, 1'b0, 1'b0, ST_OK);
            end
        end
    endtask

    // Offer one input word, with an occasional idle gap before it.
    // Called and returns at a falling edge.
    task automatic push_byte(input logic [7:0] d, input logic f, input logic l);
        int gap;
        if (!calm && $urandom_range(99) < 16) begin
            s_axis_tvalid <= 1'b0;
            gap = ($urandom_range(9) == 0) ? 5 : 1;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= f;
        s_axis_tlast  <= l;
        do @(posedge i_clk); while (!s_axis_tready);
        predict(d, f, l);
        fed++;
        @(negedge i_clk);
    endtask

    // Hold the input off until every expected word is out, then let the
    // pipeline drain.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [5:0] v);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_IDX_CHANNEL) begin
            p_chan = v;
        end else begin
            p_dir = v[0];
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic open_raw(input logic [7:0] hdr, input logic [7:0] len);
        frame_raw.delete();
        frame_raw.push_back(hdr);
        frame_raw.push_back(len);
    endtask

    // Send the raw frame as a transmit frame; cut leaves the last mark off.
    task automatic send_tx(input bit cut);
        for (int i = 0; i < frame_raw.size(); i++) begin
            push_byte(frame_raw[i], i == 0, !cut && (i == frame_raw.size() - 1));
        end
    endtask

    // Encode the raw frame with its CRC as it would arrive over the air on
    // the current channel, optionally damage one bit past the length, and
    // send it. Without full only the raw part goes out.
    task automatic send_air(input bit full, input bit damage);
        logic [23:0] c;
        logic [6:0]  w;
        logic [7:0]  m;
        int          idx;
        int          keep;
        c = CRC_SEED;
        foreach (frame_raw[i]) begin
            c = crc_after(c, frame_raw[i]);
        end
        w = p_chan | LFSR_TOP;
        frame_air.delete();
        for (int i = 0; i < frame_raw.size() + 3; i++) begin
            {w, m} = wh_step(w);
            if (i < frame_raw.size()) begin
                frame_air.push_back(flip8(frame_raw[i] ^ m));
            end else begin
                frame_air.push_back(flip8(c[8 * (i - frame_raw.size()) +: 8] ^ m));
            end
        end
        if (damage) begin
            idx = $urandom_range(2, frame_air.size() - 1);
            frame_air[idx] = frame_air[idx] ^ (8'h01 << $urandom_range(7));
        end
        keep = full ? frame_air.size() : frame_raw.size();
        for (int i = 0; i < keep; i++) begin
            push_byte(frame_air[i], i == 0, 1'($urandom_range(1)));
        end
    endtask

    function automatic void add_row(input t_row_kind kind, input logic [5:0] val,
                                    input logic [7:0] len, input int body,
                                    input logic [7:0] fill, input bit damage,
                                    input bit chk, input logic [1:0] want);
        t_plan_row r;
        r.kind   = kind;
        r.val    = val;
        r.len    = len;
        r.body   = body;
        r.fill   = fill;
        r.damage = damage;
        r.chk    = chk;
        r.want   = want;
        plan.push_back(r);
    endfunction

    // Length field for random frames: mostly short legal lengths.
    function automatic logic [7:0] pick_len();
        int sel;
        sel = $urandom_range(9);
        if (sel < 7) begin
            return 8'($urandom_range(6, 12));
        end else if (sel == 7) begin
            return 8'($urandom_range(0, 27));
        end else if (sel == 8) begin
            return 8'($urandom_range(28, 255));
        end
        return MAX_PAYLOAD_BYTES;
    endfunction

    // Receiver: accept most cycles, stall now and then.
    always @(negedge i_clk) begin
        if (!calm && $urandom_range(99) < 16) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Compare each output word with the oldest expected word.
    always @(posedge i_clk) begin : watch_out
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending.size() == 0) begin
                $error("unexpected word: out_byte %h", m_axis_tdata);
                mismatches++;
            end else begin
                want = pending.pop_front();
                if (m_axis_tdata !== want.out_byte) begin
                    $error("out_byte: expected %h, got %h", want.out_byte, m_axis_tdata);
                    mismatches++;
                end
                if (m_axis_tlast !== want.out_last) begin
                    $error("out_last: expected %b, got %b", want.out_last, m_axis_tlast);
                    mismatches++;
                end
                if (m_axis_tuser[0] !== want.check_done) begin
                    $error("check_done: expected %b, got %b", want.check_done,
                           m_axis_tuser[0]);
                    mismatches++;
                end
                if (m_axis_tuser[2:1] !== want.check_status) begin
                    $error("check_status: expected %0d, got %0d", want.check_status,
                           m_axis_tuser[2:1]);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        t_plan_row   row;
        int          ph;
        int          base;
        int          start;
        int          frames;
        logic [7:0]  len;
        int          n;
        bit          ok;
        logic        dir;
        logic [5:0]  chan;

        // Directed table, starting in transmit on the reset channel.
        // Bytes before any frame start run on the reset state.
        add_row(ROW_BYTE, 6'd0, 8'd0, 0, 8'h00, 1'b0, 1'b0, ST_OK);
        // One-byte frame: no length byte, so the length check passes.
        add_row(ROW_BYTE, 6'd3, 8'd0, 0, 8'hFF, 1'b0, 1'b1, ST_OK);
        // A byte after the last one continues the frame.
        add_row(ROW_BYTE, 6'd0, 8'd0, 0, 8'hA5, 1'b0, 1'b0, ST_OK);
        add_row(ROW_TX, 6'd0, 8'd27, 0, 8'hFF, 1'b0, 1'b1, ST_OK);
        add_row(ROW_TX, 6'd0, 8'd28, 1, 8'h00, 1'b0, 1'b1, ST_LEN);
        add_row(ROW_CHAN, 6'd0, 8'd0, 0, 8'h00, 1'b0, 1'b0, ST_OK);
        add_row(ROW_DIR, {5'd0, DIR_RX}, 8'd0, 0, 8'h00, 1'b0, 1'b0, ST_OK);
        add_row(ROW_RX, 6'd0, 8'd6, 6, 8'hFF, 1'b0, 1'b1, ST_OK);
        // Receive byte after the check, marked last: only decoded.
        add_row(ROW_BYTE, 6'd2, 8'd0, 0, 8'h00, 1'b0, 1'b0, ST_OK);
        add_row(ROW_CHAN, 6'd39, 8'd0, 0, 8'h00, 1'b0, 1'b0, ST_OK);
        add_row(ROW_RX, 6'd0, 8'd5, 0, 8'h3C, 1'b0, 1'b1, ST_LEN);
        add_row(ROW_RX, 6'd0, 8'd28, 0, 8'hC3, 1'b0, 1'b1, ST_LEN);
        add_row(ROW_RX, 6'd0, 8'd6, 6, 8'h00, 1'b1, 1'b1, ST_CRC);

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[i]) begin
            row = plan[i];
            case (row.kind)
                ROW_CHAN: begin
                    write_reg(CFG_IDX_CHANNEL, row.val);
                end
                ROW_DIR: begin
                    write_reg(CFG_IDX_DIRECTION, row.val);
                end
                default: begin
                    typed_on = row.chk;
                    typed_st = row.want;
                    if (row.kind == ROW_BYTE) begin
                        push_byte(row.fill, row.val[0], row.val[1]);
                    end else begin
                        open_raw(row.fill ^ 8'h40, row.len);
                        for (int j = 0; j < row.body; j++) begin
                            frame_raw.push_back(j[0] ? ~row.fill : row.fill);
                        end
                        if (row.kind == ROW_TX) begin
                            send_tx(1'b0);
                        end else begin
                            ok = (row.len >= LEN_MIN) && (row.len <= MAX_PAYLOAD_BYTES);
                            send_air(ok, row.damage);
                        end
                    end
                    typed_on = 1'b0;
                end
            endcase
        end

        // Random phases, each with its own channel and direction.
        base = fed;
        ph   = 0;
        while (ph < 4 || fed - base < 95) begin
            chan = (ph == 0) ? 6'd0 : (ph == 1) ? 6'd39 : 6'($urandom_range(39));
            dir  = ph[0] ? DIR_RX : DIR_TX;
            write_reg(CFG_IDX_CHANNEL, chan);
            write_reg(CFG_IDX_DIRECTION, {5'd0, dir});
            calm = (ph == 3);
            if (ph == 0) begin
                // Frame long enough to saturate the byte position counter;
                // payload values stay small so a wrap would show in the check.
                open_raw(8'($urandom_range(255)), 8'd30);
                repeat (66) frame_raw.push_back(8'($urandom_range(27)));
                send_tx(1'b0);
            end
            start  = fed;
            frames = 0;
            while (fed - start < 8) begin
                if (ph == 2 && frames == 1) begin
                    settle();
                end
                if ($urandom_range(7) == 0) begin
                    push_byte(8'($urandom_range(255)), 1'($urandom_range(1)),
                              1'($urandom_range(1)));
                end else if (dir == DIR_TX) begin
                    len = pick_len();
                    n   = (len <= 10) ? len : $urandom_range(0, 6);
                    open_raw(8'($urandom_range(255)), len);
                    repeat (n) frame_raw.push_back(8'($urandom_range(255)));
                    send_tx($urandom_range(9) == 0);
                    if ($urandom_range(5) == 0) begin
                        push_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
                    end
                end else begin
                    len = pick_len();
                    ok  = (len >= LEN_MIN) && (len <= MAX_PAYLOAD_BYTES);
                    n   = ok ? len : $urandom_range(0, 3);
                    open_raw(8'($urandom_range(255)), len);
                    repeat (n) frame_raw.push_back(8'($urandom_range(255)));
                    send_air(ok, ok && ($urandom_range(3) == 0));
                    if ($urandom_range(4) == 0) begin
                        push_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
                    end
                end
                frames++;
            end
            calm = 1'b0;
            ph++;
        end

        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending.size() != 0);
        repeat (8) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("ble_adv_frame_crc_whiten_tb: done, clean");
        end else begin
            $display("ble_adv_frame_crc_whiten_tb: done, errors");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2000000;
        $display("ble_adv_frame_crc_whiten_tb: done, errors");
        $finish;
    end

endmodule
